>>> src/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared codes, widths and controller/datapath interface types for the
// shortest-queue dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package sqd_pkg;

    localparam int NUM_QUEUES = 3;
    localparam int QIDX_W     = 2;
    localparam int TAG_W      = 16;
    localparam int SCORE_W    = 8;

    localparam logic [SCORE_W-1:0] ADMIT_THRESHOLD_RESET = 8'd50;

    typedef logic [1:0]         action_t;
    typedef logic [2:0]         status_t;
    typedef logic [QIDX_W-1:0]  qidx_t;

    localparam action_t ACT_ADD   = 2'd0;
    localparam action_t ACT_DRAIN = 2'd1;
    localparam action_t ACT_PEEK  = 2'd2;

    localparam status_t ST_ADDED     = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_PROCESSED = 3'd2;
    localparam status_t ST_FOUND     = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;
    localparam status_t ST_INVALID   = 3'd5;
    localparam status_t ST_NOTHING   = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    add_write;
        logic    peek_read;
        logic    drain_pop;
        logic    drain_start;
        logic    drain_next;
        logic    emit;
        status_t emit_status;
    } sqd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    all_full;
        logic    all_empty;
        logic    qn_invalid;
        logic    qn_empty;
        logic    cur_empty;
        logic    last_pend;
        logic    out_free;
    } sqd_sts_t;

endpackage

`default_nettype wire

>>> src/shortest_queue_dispatcher.sv
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher
// Join-shortest-queue dispatcher over three bounded FIFOs of (tag, score)
// entries with add, drain-all and peek operations.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    action, student_tag, score, queue_number
//  result   out_valid/out_ready  status, queue_index, out_tag, out_score,
//                                admitted, last
//  config   cfg_valid/cfg_ready  admit_threshold
//
//  An add, a rejected add, an invalid or empty peek and an empty drain answer
//  from the dispatch state; a peek that finds an entry goes on to S_PK_EMIT
//  for the registered RAM read. A drain scans the queues in order, skipping
//  empty ones, and pops one entry at a time through the single RAM read port.
//  Reset clears the counts and head pointers; no clearing pass is needed.
//  A stalled result holds the output register and the controller waits.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_queue_dispatcher
    import sqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire action_t            action,
    input  wire logic [TAG_W-1:0]   student_tag,
    input  wire logic [SCORE_W-1:0] score,
    input  wire qidx_t              queue_number,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output status_t                 status,
    output qidx_t                   queue_index,
    output logic [TAG_W-1:0]        out_tag,
    output logic [SCORE_W-1:0]      out_score,
    output logic                    admitted,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [SCORE_W-1:0] admit_threshold
);

    sqd_cmd_t cmd;
    sqd_sts_t sts;

    // The threshold register takes a transfer in any cycle.
    assign cfg_ready = 1'b1;

    sqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sqd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (action),
        .student_tag     (student_tag),
        .score           (score),
        .queue_number    (queue_number),
        .cfg_valid       (cfg_valid),
        .admit_threshold (admit_threshold),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .queue_index     (queue_index),
        .out_tag         (out_tag),
        .out_score       (out_score),
        .admitted        (admitted),
        .last            (last)
    );

endmodule

`default_nettype wire

>>> src/sqd_ram.sv
// ----------------------------------------------------------------------------
// sqd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 48,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/sqd_ctrl.sv
// ----------------------------------------------------------------------------
// sqd_ctrl
// Controller state machine: sequences add, peek and drain operations and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_ctrl
    import sqd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sqd_sts_t sts,
    output sqd_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_DR_SCAN  = 3'd2;
    localparam logic [2:0] S_DR_EMIT  = 3'd3;
    localparam logic [2:0] S_PK_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.action)
                    ACT_ADD:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (sts.all_full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.add_write   = 1'b1;
                                cmd.emit_status = ST_ADDED;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (sts.all_empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_NOTHING;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.drain_start = 1'b1;
                            state_next      = S_DR_SCAN;
                        end
                    end
                    ACT_PEEK:
                    begin
                        if (sts.qn_invalid || sts.qn_empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = sts.qn_invalid ? ST_INVALID : ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.peek_read = 1'b1;
                            state_next    = S_PK_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DR_SCAN:
            begin
                // Skip empty queues; at least one entry remains while here.
                if (sts.cur_empty)
                begin
                    cmd.drain_next = 1'b1;
                end
                else
                begin
                    cmd.drain_pop = 1'b1;
                    state_next    = S_DR_EMIT;
                end
            end
            S_DR_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_PROCESSED;
                    state_next      = sts.last_pend ? S_IDLE : S_DR_SCAN;
                end
            end
            S_PK_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FOUND;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/sqd_datapath.sv
// ----------------------------------------------------------------------------
// sqd_datapath
// Queue bookkeeping (counts, head pointers), entry RAM, threshold register,
// input capture and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_datapath
    import sqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sqd_cmd_t           cmd,
    output sqd_sts_t                sts,
    input  wire action_t            action,
    input  wire logic [TAG_W-1:0]   student_tag,
    input  wire logic [SCORE_W-1:0] score,
    input  wire qidx_t              queue_number,
    input  wire logic               cfg_valid,
    input  wire logic [SCORE_W-1:0] admit_threshold,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output status_t                 status,
    output qidx_t                   queue_index,
    output logic [TAG_W-1:0]        out_tag,
    output logic [SCORE_W-1:0]      out_score,
    output logic                    admitted,
    output logic                    last
);

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int SUM_W   = CNT_W + 1;
    localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int ENTRY_W = TAG_W + SCORE_W;

    logic [CNT_W-1:0]   counts_reg [NUM_QUEUES];
    logic [CNT_W-1:0]   counts_next[NUM_QUEUES];
    logic [PTR_W-1:0]   heads_reg  [NUM_QUEUES];
    logic [PTR_W-1:0]   heads_next [NUM_QUEUES];
    qidx_t              cur_q_reg;
    qidx_t              cur_q_next;
    logic               last_pend_reg;
    logic               last_pend_next;
    logic [SCORE_W-1:0] threshold_reg;

    action_t            action_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SCORE_W-1:0] score_reg;
    qidx_t              qn_reg;

    logic               out_valid_reg;
    status_t            status_reg;
    qidx_t              queue_index_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               admitted_reg;
    logic               last_reg;

    qidx_t              best_q;
    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   tail_wrap;
    logic [PTR_W-1:0]   tail_idx;
    qidx_t              rd_q;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               later_empty;
    logic               out_free;

    status_t            status_next;
    qidx_t              queue_index_next;
    logic [TAG_W-1:0]   out_tag_next;
    logic [SCORE_W-1:0] out_score_next;
    logic               admitted_next;
    logic               last_next;

    // Shortest queue, lowest index on a tie.
    always_comb
    begin
        best_q = '0;
        for (int q = 1; q < NUM_QUEUES; q++)
        begin
            if (counts_reg[q] < counts_reg[best_q])
            begin
                best_q = QIDX_W'(q);
            end
        end
    end

    // Tail slot of the chosen queue: (head + count) wrapped into the ring.
    always_comb
    begin
        tail_sum  = SUM_W'(heads_reg[best_q]) + SUM_W'(counts_reg[best_q]);
        tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                      : tail_sum;
        tail_idx  = tail_wrap[PTR_W-1:0];
    end

    assign rd_q    = cmd.drain_pop ? cur_q_reg : qn_reg;
    assign wr_addr = ADDR_W'(best_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_idx);
    assign rd_addr = ADDR_W'(rd_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(heads_reg[rd_q]);

    sqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (cmd.add_write),
        .wr_addr (wr_addr),
        .wr_data ({tag_reg, score_reg}),
        .rd_en   (cmd.peek_read || cmd.drain_pop),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // True when every queue after the one being drained is empty.
    always_comb
    begin
        later_empty = 1'b1;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (QIDX_W'(q) > cur_q_reg && counts_reg[q] != '0)
            begin
                later_empty = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            counts_next[q] = counts_reg[q];
            heads_next[q]  = heads_reg[q];
        end
        cur_q_next     = cur_q_reg;
        last_pend_next = last_pend_reg;
        if (cmd.add_write)
        begin
            counts_next[best_q] = counts_reg[best_q] + CNT_W'(1);
        end
        if (cmd.drain_start)
        begin
            cur_q_next = '0;
        end
        if (cmd.drain_next)
        begin
            cur_q_next = cur_q_reg + QIDX_W'(1);
        end
        if (cmd.drain_pop)
        begin
            counts_next[cur_q_reg] = counts_reg[cur_q_reg] - CNT_W'(1);
            heads_next[cur_q_reg]  = (heads_reg[cur_q_reg] == PTR_W'(QUEUE_DEPTH - 1))
                                     ? '0 : heads_reg[cur_q_reg] + PTR_W'(1);
            last_pend_next = (counts_reg[cur_q_reg] == CNT_W'(1)) && later_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                counts_reg[q] <= '0;
                heads_reg[q]  <= '0;
            end
            cur_q_reg     <= '0;
            last_pend_reg <= 1'b0;
            threshold_reg <= ADMIT_THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                counts_reg[q] <= counts_next[q];
                heads_reg[q]  <= heads_next[q];
            end
            cur_q_reg     <= cur_q_next;
            last_pend_reg <= last_pend_next;
            if (cfg_valid)
            begin
                threshold_reg <= admit_threshold;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            tag_reg    <= student_tag;
            score_reg  <= score;
            qn_reg     <= queue_number;
        end
        if (cmd.emit)
        begin
            status_reg      <= status_next;
            queue_index_reg <= queue_index_next;
            out_tag_reg     <= out_tag_next;
            out_score_reg   <= out_score_next;
            admitted_reg    <= admitted_next;
            last_reg        <= last_next;
        end
    end

    always_comb
    begin
        status_next      = cmd.emit_status;
        queue_index_next = '0;
        out_tag_next     = '0;
        out_score_next   = '0;
        admitted_next    = 1'b0;
        last_next        = 1'b1;
        case (cmd.emit_status)
            ST_ADDED:
            begin
                queue_index_next = best_q;
            end
            ST_PROCESSED:
            begin
                queue_index_next = cur_q_reg;
                out_tag_next     = rd_data[ENTRY_W-1:SCORE_W];
                out_score_next   = rd_data[SCORE_W-1:0];
                admitted_next    = rd_data[SCORE_W-1:0] > threshold_reg;
                last_next        = last_pend_reg;
            end
            ST_FOUND:
            begin
                queue_index_next = qn_reg;
                out_tag_next     = rd_data[ENTRY_W-1:SCORE_W];
                out_score_next   = rd_data[SCORE_W-1:0];
            end
            ST_EMPTY:
            begin
                queue_index_next = qn_reg;
            end
            default:
            begin
                queue_index_next = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts            = '0;
        sts.action     = action_reg;
        sts.all_full   = counts_reg[best_q] >= CNT_W'(QUEUE_DEPTH);
        sts.all_empty  = 1'b1;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (counts_reg[q] != '0)
            begin
                sts.all_empty = 1'b0;
            end
        end
        sts.qn_invalid = qn_reg >= QIDX_W'(NUM_QUEUES);
        sts.qn_empty   = sts.qn_invalid ? 1'b1 : (counts_reg[qn_reg] == '0);
        sts.cur_empty  = counts_reg[cur_q_reg] == '0;
        sts.last_pend  = last_pend_reg;
        sts.out_free   = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign queue_index = queue_index_reg;
    assign out_tag     = out_tag_reg;
    assign out_score   = out_score_reg;
    assign admitted    = admitted_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
